// ----- sv/fdcc_pkg.sv -----
`timescale 1ns / 1ps

package fdcc_pkg;

    localparam int SAMPLE_W        = 10;
    localparam int SAMPLE_MAX      = (1 << SAMPLE_W) - 1;
    localparam int SHORT_WINDOW    = 5;
    localparam int BASELINE_LENGTH = 100;

    localparam int LEVEL_W     = 17;
    localparam int POWER_W     = 8;
    localparam int CFG_DATA_W  = 17;
    localparam int CFG_INDEX_W = 2;

    localparam int Q_FRAC       = 16;
    localparam int Q_ONE        = 1 << Q_FRAC;
    localparam int Q_HALF       = 1 << (Q_FRAC - 1);
    localparam int SCALE_SHIFT  = Q_FRAC - SAMPLE_W;

    localparam int SHORT_W     = $clog2(SHORT_WINDOW * SAMPLE_MAX + 1);
    localparam int SLOT_W      = (SHORT_WINDOW > 1) ? $clog2(SHORT_WINDOW) : 1;
    localparam int SLOT_RESET  = 1 % SHORT_WINDOW;
    localparam int CNT_MAX     = BASELINE_LENGTH + 1;
    localparam int CNT_W       = $clog2(CNT_MAX + 1);
    localparam int BSUM_W      = $clog2(BASELINE_LENGTH * SAMPLE_MAX + 1);

    // floor(y / d) = (y * ceil(2^k / d)) >> k with k = width(y) + clog2(d)
    localparam int     SHORT_Y_W = SHORT_W + SCALE_SHIFT;
    localparam int     SHORT_K   = SHORT_Y_W + $clog2(SHORT_WINDOW);
    localparam int     SHORT_M_W = SHORT_Y_W + 2;
    localparam int     SHORT_P_W = SHORT_Y_W + SHORT_M_W;
    localparam longint SHORT_M   =
        ((longint'(1) << SHORT_K) + SHORT_WINDOW - 1) / SHORT_WINDOW;

    localparam int     BASE_Y_W = BSUM_W + SCALE_SHIFT;
    localparam int     BASE_K   = BASE_Y_W + $clog2(BASELINE_LENGTH);
    localparam int     BASE_M_W = BASE_Y_W + 2;
    localparam int     BASE_P_W = BASE_Y_W + BASE_M_W;
    localparam longint BASE_M   =
        ((longint'(1) << BASE_K) + BASELINE_LENGTH - 1) / BASELINE_LENGTH;

    localparam int GREEN_GAIN = 1000;
    localparam int EDGE_GAIN  = 256;
    localparam int GAIN_W     = 10;
    localparam int POWER_MAX  = (1 << POWER_W) - 1;

    localparam int NEUTRAL_LOW_RESET  = 26214;
    localparam int NEUTRAL_HIGH_RESET = 39322;
    localparam int POWER_FLOOR_RESET  = 10;

    typedef enum logic [1:0] {
        COLOR_GREEN = 2'd0,
        COLOR_BLUE  = 2'd1,
        COLOR_RED   = 2'd2
    } color_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_NEUTRAL_LOW  = 2'd0,
        REG_NEUTRAL_HIGH = 2'd1,
        REG_POWER_FLOOR  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] neutral_low;
        logic [LEVEL_W-1:0] neutral_high;
        logic [POWER_W-1:0] power_floor;
    } cfg_t;

endpackage

// ----- sv/fdcc_classify.sv -----
`timescale 1ns / 1ps

module fdcc_classify
    import fdcc_pkg::*;
(
    input  logic [LEVEL_W-1:0] short_q,
    input  logic [LEVEL_W-1:0] base_q,
    input  cfg_t               cfg,
    output color_t             color,
    output logic [POWER_W-1:0] power,
    output logic [LEVEL_W-1:0] level
);

    localparam int PROD_W = LEVEL_W + GAIN_W;
    localparam int SUM_W  = PROD_W - Q_FRAC + 1;

    logic [LEVEL_W-1:0]      short_biased;
    logic signed [LEVEL_W:0] diff;
    logic [LEVEL_W-1:0]      span;
    logic [GAIN_W-1:0]       gain;
    logic [PROD_W-1:0]       prod;
    logic [SUM_W-1:0]        power_sum;

    assign short_biased = short_q + LEVEL_W'(Q_HALF);
    assign diff = $signed({1'b0, short_biased}) - $signed({1'b0, base_q});

    always_comb
    begin
        if (diff < 0)
        begin
            level = '0;
        end
        else if (diff > $signed((LEVEL_W + 1)'(Q_ONE)))
        begin
            level = LEVEL_W'(Q_ONE);
        end
        else
        begin
            level = diff[LEVEL_W-1:0];
        end
    end

    always_comb
    begin
        if (level > cfg.neutral_low && level < cfg.neutral_high)
        begin
            color = COLOR_GREEN;
            gain  = GAIN_W'(GREEN_GAIN);
            if (level < LEVEL_W'(Q_HALF))
            begin
                span = level - cfg.neutral_low;
            end
            else
            begin
                span = cfg.neutral_high - level;
            end
        end
        else if (level <= cfg.neutral_low)
        begin
            color = COLOR_BLUE;
            gain  = GAIN_W'(EDGE_GAIN);
            span  = cfg.neutral_low - level;
        end
        else
        begin
            color = COLOR_RED;
            gain  = GAIN_W'(EDGE_GAIN);
            span  = level - cfg.neutral_high;
        end
    end

    assign prod      = PROD_W'(span) * PROD_W'(gain);
    assign power_sum = SUM_W'(prod[PROD_W-1:Q_FRAC]) + SUM_W'(cfg.power_floor);
    assign power     = (power_sum > SUM_W'(POWER_MAX)) ? POWER_W'(POWER_MAX)
                                                       : power_sum[POWER_W-1:0];

endmodule

// ----- sv/field_delta_color_classifier_top.sv -----
`timescale 1ns / 1ps

// One sample enters per cycle while in_stall is low; its result passes these register stages:
// the first register stage updates the five-sample moving sum and the baseline and scales both
// to Q16 by constant-reciprocal multiplies, the second forms the clamped level, the color and
// the drive power (one multiply by the band gain). The baseline is the average of the first
// 100 samples, reads zero before it, and is frozen once the hundredth sample is taken;
// calibrating is high for those first 100 results. Throughput is one item per cycle,
// limited only by the output stall. Write the band edges and the power floor only while no
// request is in flight.
module field_delta_color_classifier_top
    import fdcc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [SAMPLE_W-1:0]    sample,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             color,
    output logic [POWER_W-1:0]     drive_power,
    output logic [LEVEL_W-1:0]     level,
    output logic                   calibrating
);

    cfg_t                cfg_reg;
    logic [SAMPLE_W-1:0] window_reg [SHORT_WINDOW];
    logic [SHORT_W-1:0]  short_sum_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [BSUM_W-1:0]   bsum_reg;
    logic [LEVEL_W-1:0]  base_reg;
    logic [CNT_W-1:0]    cnt_reg;

    logic                s1_valid_reg;
    logic [LEVEL_W-1:0]  s1_short_q_reg;
    logic [LEVEL_W-1:0]  s1_base_q_reg;
    logic                s1_cal_reg;

    logic                out_valid_reg;
    color_t              color_reg;
    logic [POWER_W-1:0]  power_reg;
    logic [LEVEL_W-1:0]  level_reg;
    logic                cal_reg;

    logic                in_accept;
    logic                s2_free;
    logic                s2_load;
    logic [CNT_W-1:0]    cnt_next;
    logic                cal_next;
    logic                freeze;
    logic [SHORT_W-1:0]  short_sum_next;
    logic [SLOT_W-1:0]   slot_next;
    logic [BSUM_W-1:0]   bsum_next;
    logic [LEVEL_W-1:0]  base_next;
    logic [SHORT_P_W-1:0] short_prod;
    logic [BASE_P_W-1:0]  base_prod;
    logic [LEVEL_W-1:0]  short_q_next;

    color_t              cls_color;
    logic [POWER_W-1:0]  cls_power;
    logic [LEVEL_W-1:0]  cls_level;

    assign s2_free   = !out_valid_reg || !out_stall;
    assign s2_load   = s1_valid_reg && s2_free;
    assign in_stall  = s1_valid_reg && !s2_free;
    assign in_accept = in_valid && !in_stall;

    assign cnt_next = (cnt_reg < CNT_W'(CNT_MAX)) ? cnt_reg + CNT_W'(1) : cnt_reg;
    assign cal_next = cnt_next <= CNT_W'(BASELINE_LENGTH);
    assign freeze   = cnt_next == CNT_W'(BASELINE_LENGTH);

    assign short_sum_next = short_sum_reg - SHORT_W'(window_reg[slot_reg]) + SHORT_W'(sample);
    assign slot_next = (slot_reg == SLOT_W'(SHORT_WINDOW - 1)) ? '0 : slot_reg + SLOT_W'(1);
    assign bsum_next = cal_next ? bsum_reg + BSUM_W'(sample) : bsum_reg;

    assign short_prod = SHORT_P_W'({short_sum_next, {SCALE_SHIFT{1'b0}}})
                      * SHORT_P_W'(SHORT_M);
    assign base_prod  = BASE_P_W'({bsum_next, {SCALE_SHIFT{1'b0}}}) * BASE_P_W'(BASE_M);

    assign short_q_next = short_prod[SHORT_K +: LEVEL_W];
    assign base_next    = freeze ? base_prod[BASE_K +: LEVEL_W] : base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.neutral_low  <= LEVEL_W'(NEUTRAL_LOW_RESET);
            cfg_reg.neutral_high <= LEVEL_W'(NEUTRAL_HIGH_RESET);
            cfg_reg.power_floor  <= POWER_W'(POWER_FLOOR_RESET);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_NEUTRAL_LOW:  cfg_reg.neutral_low  <= cfg_data[LEVEL_W-1:0];
                REG_NEUTRAL_HIGH: cfg_reg.neutral_high <= cfg_data[LEVEL_W-1:0];
                REG_POWER_FLOOR:  cfg_reg.power_floor  <= cfg_data[POWER_W-1:0];
                default:          ;
            endcase
        end
    end

    // advance the running state on every request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SHORT_WINDOW; i++)
            begin
                window_reg[i] <= '0;
            end
            short_sum_reg <= '0;
            slot_reg      <= SLOT_W'(SLOT_RESET);
            bsum_reg      <= '0;
            base_reg      <= '0;
            cnt_reg       <= '0;
        end
        else if (in_accept)
        begin
            window_reg[slot_reg] <= sample;
            short_sum_reg        <= short_sum_next;
            slot_reg             <= slot_next;
            bsum_reg             <= bsum_next;
            base_reg             <= base_next;
            cnt_reg              <= cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s2_load)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_short_q_reg <= short_q_next;
            s1_base_q_reg  <= base_next;
            s1_cal_reg     <= cal_next;
        end
    end

    fdcc_classify u_classify (
        .short_q (s1_short_q_reg),
        .base_q  (s1_base_q_reg),
        .cfg     (cfg_reg),
        .color   (cls_color),
        .power   (cls_power),
        .level   (cls_level)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            color_reg <= cls_color;
            power_reg <= cls_power;
            level_reg <= cls_level;
            cal_reg   <= s1_cal_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign color       = color_reg;
    assign drive_power = power_reg;
    assign level       = level_reg;
    assign calibrating = cal_reg;

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> level_reg <= LEVEL_W'(Q_ONE))
        else $error("level above one");

    a_base_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == CNT_W'(CNT_MAX) |=> $stable(base_reg))
        else $error("baseline moved after freeze");

    a_cal_done: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && cnt_reg == CNT_W'(CNT_MAX)) |=> !s1_cal_reg)
        else $error("calibrating after baseline frozen");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_free) |=> s1_valid_reg)
        else $error("blocked request dropped");

    a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> short_sum_reg <= SHORT_W'(SHORT_WINDOW * SAMPLE_MAX))
        else $error("moving sum out of range");

endmodule
